// File: sv/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPCF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SPCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/spcf_pkg.sv
// shared types, codes and constants of the stepper position command block
package spcf_pkg;

	localparam int STEP_W     = 24;
	localparam int ANGLE_W    = 24;
	localparam int SPR_W      = 28;
	localparam int REV_W      = 16;
	localparam int CNT_W      = 16;
	localparam int PROD_W     = SPR_W + ANGLE_W;
	localparam int RND_SHIFT  = 36;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam logic [SPR_W-1:0]          RST_STEPS_PER_RADIAN = 28'd2086167;
	localparam logic [REV_W-1:0]          RST_STEPS_PER_REV    = 16'd200;
	localparam logic signed [ANGLE_W-1:0] RST_MIN_ANGLE        = 24'sd0;
	localparam logic signed [ANGLE_W-1:0] RST_MAX_ANGLE        = 24'sd6588397;
	localparam logic                      RST_FULL_CIRCLE      = 1'b1;
	localparam logic [CNT_W-1:0]          RST_MIN_STEP_COMMAND = 16'd1;
	localparam logic [CNT_W-1:0]          RST_SETTLE_COUNT_MAX = 16'd0;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEPS_PER_RADIAN = 3'd0,
		REG_STEPS_PER_REV    = 3'd1,
		REG_MIN_ANGLE        = 3'd2,
		REG_MAX_ANGLE        = 3'd3,
		REG_FULL_CIRCLE      = 3'd4,
		REG_MIN_STEP_COMMAND = 3'd5,
		REG_SETTLE_COUNT_MAX = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SPR_W-1:0]   steps_per_radian;
		logic [REV_W-1:0]   steps_per_rev;
		logic [ANGLE_W-1:0] min_angle;
		logic [ANGLE_W-1:0] max_angle;
		logic               full_circle;
		logic [CNT_W-1:0]   min_step_command;
		logic [CNT_W-1:0]   settle_count_max;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic rnd;
		logic diff;
		logic div_step;
		logic fix;
		logic sat;
		logic sel_idle;
		logic retire;
		cmd_t out_cmd;
		logic set_commanded;
		logic settle_clr;
		logic settle_inc;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic accepted;
		logic moving;
		logic reach;
		logic div_done;
		logic settle_reached;
	} dp_sts_t;

endpackage

// File: sv/spcf_ifs.sv
// request channel interfaces for control ticks and command results
interface spcf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [spcf_pkg::STEP_W-1:0]  current_position;
	logic signed [spcf_pkg::ANGLE_W-1:0] reference_angle;
	logic                                motor_moving;

	modport source(output valid, current_position, reference_angle, motor_moving, input ready);
	modport sink(input valid, current_position, reference_angle, motor_moving, output ready);
endinterface

interface spcf_out_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         command;
	logic signed [spcf_pkg::STEP_W-1:0] steps_to_move;

	modport source(output valid, command, steps_to_move, input ready);
	modport sink(input valid, command, steps_to_move, output ready);
endinterface

// File: sv/stepper_position_command_fsm.sv
// top level of the stepper position command state machine
//
// tick (sink): one request per control tick with current_position (steps),
//   reference_angle (rad, 20 fraction bits) and motor_moving.
// result (source): exactly one request per tick with command (none, move,
//   stop) and steps_to_move, nonzero only for a move.
// write_en / write_index / write_data: configuration writes, one register per
//   edge, to be issued only while no tick is in flight.
// timing: a tick passes through load, multiply, rounding, difference, the
//   remainder unit, wrap, saturate and retire before its result is offered;
//   tick.ready returns with the result, so a new tick is taken only once the
//   last one is through. The remainder unit works on DW dividend bits,
//   DW = max(POSITION_BITS, 24) + 1, and resolves one dividend bit per cycle.
// the result sits in an output register: the next tick is taken while it
//   waits, and a stalled receiver only holds the following tick in its final
//   cycle until the register frees.
// reset: configuration returns to its defaults, mode goes idle, desired and
//   commanded positions and the settle counter clear, no result is pending.
module stepper_position_command_fsm #(
	parameter int POSITION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	spcf_in_if.sink                         tick,
	spcf_out_if.source                      result,
	input  logic                            write_en,
	input  logic [spcf_pkg::CFG_IDX_W-1:0]  write_index,
	input  logic [spcf_pkg::CFG_DATA_W-1:0] write_data
);

	spcf_pkg::cfg_t    cfg;
	spcf_pkg::dp_ctl_t ctl;
	spcf_pkg::dp_sts_t sts;

	spcf_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.cfg         (cfg)
	);

	spcf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick.valid),
		.tick_ready   (tick.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.ctl          (ctl)
	);

	spcf_dp #(
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.ctl              (ctl),
		.sts              (sts),
		.current_position (tick.current_position),
		.reference_angle  (tick.reference_angle),
		.motor_moving     (tick.motor_moving),
		.command          (result.command),
		.steps_to_move    (result.steps_to_move)
	);

endmodule

// File: sv/spcf_cfg.sv
// configuration register file
module spcf_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_en,
	input  logic [spcf_pkg::CFG_IDX_W-1:0]      write_index,
	input  logic [spcf_pkg::CFG_DATA_W-1:0]     write_data,
	output spcf_pkg::cfg_t                      cfg
);

	spcf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_radian <= spcf_pkg::RST_STEPS_PER_RADIAN;
			cfg_q.steps_per_rev    <= spcf_pkg::RST_STEPS_PER_REV;
			cfg_q.min_angle        <= spcf_pkg::RST_MIN_ANGLE;
			cfg_q.max_angle        <= spcf_pkg::RST_MAX_ANGLE;
			cfg_q.full_circle      <= spcf_pkg::RST_FULL_CIRCLE;
			cfg_q.min_step_command <= spcf_pkg::RST_MIN_STEP_COMMAND;
			cfg_q.settle_count_max <= spcf_pkg::RST_SETTLE_COUNT_MAX;
		end else if (write_en) begin
			case (spcf_pkg::reg_idx_t'(write_index))
				spcf_pkg::REG_STEPS_PER_RADIAN: begin
					cfg_q.steps_per_radian <= write_data[spcf_pkg::SPR_W-1:0];
				end
				spcf_pkg::REG_STEPS_PER_REV: begin
					cfg_q.steps_per_rev <= write_data[spcf_pkg::REV_W-1:0];
				end
				spcf_pkg::REG_MIN_ANGLE: begin
					cfg_q.min_angle <= write_data[spcf_pkg::ANGLE_W-1:0];
				end
				spcf_pkg::REG_MAX_ANGLE: begin
					cfg_q.max_angle <= write_data[spcf_pkg::ANGLE_W-1:0];
				end
				spcf_pkg::REG_FULL_CIRCLE: begin
					cfg_q.full_circle <= write_data[0];
				end
				spcf_pkg::REG_MIN_STEP_COMMAND: begin
					cfg_q.min_step_command <= write_data[spcf_pkg::CNT_W-1:0];
				end
				spcf_pkg::REG_SETTLE_COUNT_MAX: begin
					cfg_q.settle_count_max <= write_data[spcf_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/spcf_ctrl.sv
// sequencing state machine and motion mode controller
module spcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  spcf_pkg::dp_sts_t sts,
	output spcf_pkg::dp_ctl_t ctl
);

	typedef enum logic [7:0] {
		ST_WAIT = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_RND  = 8'b0000_0100,
		ST_DIFF = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_FIX  = 8'b0010_0000,
		ST_SAT  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} seq_state_t;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'b0001,
		MODE_MOVING   = 4'b0010,
		MODE_STOPPING = 4'b0100,
		MODE_SETTLING = 4'b1000
	} mode_t;

	seq_state_t state_q, state_d;
	mode_t      mode_q, mode_d;
	logic       out_valid_q, out_valid_d;
	logic       slot_free;

	assign slot_free  = !out_valid_q || result_ready;
	assign tick_ready = (state_q == ST_WAIT);

	always_comb begin
		ctl          = '0;
		ctl.out_cmd  = spcf_pkg::CMD_NONE;
		ctl.sel_idle = (mode_q == MODE_IDLE);
		state_d      = state_q;
		mode_d       = mode_q;

		case (state_q)
			ST_WAIT: begin
				if (tick_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_RND;
			end
			ST_RND: begin
				ctl.rnd = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				ctl.diff = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				ctl.fix = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				ctl.sat = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					ctl.retire = 1'b1;
					state_d    = ST_WAIT;
					case (mode_q)
						MODE_IDLE: begin
							if (sts.accepted && sts.reach) begin
								ctl.out_cmd       = spcf_pkg::CMD_MOVE;
								ctl.set_commanded = 1'b1;
								mode_d            = MODE_MOVING;
							end
						end
						MODE_MOVING: begin
							if (sts.reach) begin
								ctl.out_cmd = spcf_pkg::CMD_STOP;
								mode_d      = MODE_STOPPING;
							end else if (!sts.moving) begin
								ctl.settle_clr = 1'b1;
								mode_d         = MODE_SETTLING;
							end
						end
						MODE_STOPPING: begin
							if (!sts.moving) begin
								ctl.settle_clr = 1'b1;
								mode_d         = MODE_SETTLING;
							end
						end
						MODE_SETTLING: begin
							if (sts.settle_reached) begin
								mode_d = MODE_IDLE;
							end else begin
								ctl.settle_inc = 1'b1;
							end
						end
						default: begin
							mode_d = MODE_IDLE;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	// result slot fills on retire, empties when the receiver takes it
	always_comb begin
		if (ctl.retire) begin
			out_valid_d = 1'b1;
		end else if (result_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			mode_q      <= MODE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign result_valid = out_valid_q;

endmodule

// File: sv/spcf_dp.sv
// datapath: angle scaling, step delta, wrap remainder and result register
module spcf_dp #(
	parameter int POSITION_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spcf_pkg::cfg_t                      cfg,
	input  spcf_pkg::dp_ctl_t                   ctl,
	output spcf_pkg::dp_sts_t                   sts,
	input  logic signed [spcf_pkg::STEP_W-1:0]  current_position,
	input  logic signed [spcf_pkg::ANGLE_W-1:0] reference_angle,
	input  logic                                motor_moving,
	output logic [1:0]                          command,
	output logic signed [spcf_pkg::STEP_W-1:0]  steps_to_move
);

	localparam int PB = POSITION_BITS;
	localparam int DW = ((PB > spcf_pkg::STEP_W) ? PB : spcf_pkg::STEP_W) + 1;
	localparam int CW = $clog2(DW);
	localparam int NW = spcf_pkg::REV_W;

	localparam logic signed [DW-1:0] POS_HI = DW'((64'sd1 <<< (PB - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] POS_LO = ~POS_HI;
	localparam logic [spcf_pkg::PROD_W:0] RND_HALF =
		(spcf_pkg::PROD_W + 1)'(1) << (spcf_pkg::RND_SHIFT - 1);

	function automatic logic signed [PB-1:0] sat_pos(input logic signed [DW-1:0] v);
		if (v > POS_HI) begin
			return POS_HI[PB-1:0];
		end else if (v < POS_LO) begin
			return POS_LO[PB-1:0];
		end
		return v[PB-1:0];
	endfunction

	logic signed [spcf_pkg::STEP_W-1:0] cur_q;
	logic [spcf_pkg::ANGLE_W-1:0]       ang_mag_q;
	logic                               ang_neg_q;
	logic                               moving_q;
	logic                               acc_q;
	logic [spcf_pkg::PROD_W-1:0]        prod_q;
	logic signed [PB-1:0]               desired_q;
	logic signed [PB-1:0]               commanded_q;
	logic [spcf_pkg::CNT_W-1:0]         settle_q;
	logic signed [DW-1:0]               d_q;
	logic                               d_neg_q;
	logic [DW-1:0]                      dvd_q;
	logic [NW-1:0]                      rem_q;
	logic [CW-1:0]                      cnt_q;
	logic signed [DW-1:0]               wd_q;
	logic signed [PB-1:0]               delta_q;
	logic [1:0]                         cmd_q;
	logic signed [spcf_pkg::STEP_W-1:0] steps_q;

	logic signed [spcf_pkg::ANGLE_W-1:0] ang_min;
	logic signed [spcf_pkg::ANGLE_W-1:0] ang_max;
	logic                                in_range;
	logic [spcf_pkg::PROD_W:0]           rnd_sum;
	logic signed [DW-1:0]                rnd_v;
	logic signed [DW-1:0]                diff_v;
	logic [NW:0]                         rem_sh;
	logic [NW:0]                         n_ext;
	logic                                wrap;
	logic signed [DW-1:0]                rem_s;
	logic signed [DW-1:0]                half_s;
	logic signed [DW-1:0]                n_s;
	logic signed [DW-1:0]                wrap_v;
	logic signed [DW-1:0]                delta_x;
	logic [DW-1:0]                       delta_mag;

	assign ang_min  = cfg.min_angle;
	assign ang_max  = cfg.max_angle;
	assign in_range = (reference_angle >= ang_min) && (reference_angle <= ang_max);

	// round half away from zero on the magnitude, then restore the sign
	always_comb begin
		rnd_sum = {1'b0, prod_q} + RND_HALF;
		rnd_v   = DW'(rnd_sum[spcf_pkg::PROD_W:spcf_pkg::RND_SHIFT]);
		if (ang_neg_q) begin
			rnd_v = -rnd_v;
		end
	end

	always_comb begin
		if (ctl.sel_idle) begin
			diff_v = DW'(desired_q) - DW'(cur_q);
		end else begin
			diff_v = DW'(commanded_q) - DW'(desired_q);
		end
	end

	// one restoring remainder step per cycle
	assign n_ext  = {1'b0, cfg.steps_per_rev};
	assign rem_sh = {rem_q, dvd_q[DW-1]};

	always_comb begin
		wrap   = cfg.full_circle && (cfg.steps_per_rev != '0);
		n_s    = DW'(cfg.steps_per_rev);
		half_s = DW'(cfg.steps_per_rev >> 1);
		rem_s  = DW'(rem_q);
		if (d_neg_q) begin
			rem_s = -rem_s;
		end
		if (!wrap) begin
			wrap_v = d_q;
		end else if (rem_s > half_s) begin
			wrap_v = rem_s - n_s;
		end else if (rem_s < -half_s) begin
			wrap_v = rem_s + n_s;
		end else begin
			wrap_v = rem_s;
		end
	end

	assign delta_x   = DW'(delta_q);
	assign delta_mag = delta_x[DW-1] ? DW'(-delta_x) : DW'(delta_x);

	assign sts.accepted       = acc_q;
	assign sts.moving         = moving_q;
	assign sts.reach          = (delta_mag >= DW'(cfg.min_step_command));
	assign sts.div_done       = (cnt_q == CW'(DW - 1));
	assign sts.settle_reached = (settle_q >= cfg.settle_count_max);

	// block state kept across ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q   <= '0;
			commanded_q <= '0;
			settle_q    <= '0;
		end else begin
			if (ctl.rnd && acc_q) begin
				desired_q <= sat_pos(rnd_v);
			end
			if (ctl.set_commanded) begin
				commanded_q <= desired_q;
			end
			if (ctl.settle_clr) begin
				settle_q <= '0;
			end else if (ctl.settle_inc) begin
				settle_q <= settle_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cur_q     <= current_position;
			ang_neg_q <= reference_angle[spcf_pkg::ANGLE_W-1];
			ang_mag_q <= reference_angle[spcf_pkg::ANGLE_W-1] ?
				spcf_pkg::ANGLE_W'(-reference_angle) : spcf_pkg::ANGLE_W'(reference_angle);
			moving_q  <= motor_moving;
			acc_q     <= cfg.full_circle || in_range;
		end
		if (ctl.mul) begin
			prod_q <= ang_mag_q * cfg.steps_per_radian;
		end
		if (ctl.diff) begin
			d_q     <= diff_v;
			d_neg_q <= diff_v[DW-1];
			dvd_q   <= diff_v[DW-1] ? DW'(-diff_v) : DW'(diff_v);
			rem_q   <= '0;
			cnt_q   <= '0;
		end
		if (ctl.div_step) begin
			if (rem_sh >= n_ext) begin
				rem_q <= NW'(rem_sh - n_ext);
			end else begin
				rem_q <= rem_sh[NW-1:0];
			end
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.fix) begin
			wd_q <= wrap_v;
		end
		if (ctl.sat) begin
			delta_q <= sat_pos(wd_q);
		end
		if (ctl.retire) begin
			cmd_q <= ctl.out_cmd;
			if (ctl.out_cmd == spcf_pkg::CMD_MOVE) begin
				steps_q <= spcf_pkg::STEP_W'(delta_q);
			end else begin
				steps_q <= '0;
			end
		end
	end

	assign command       = cmd_q;
	assign steps_to_move = steps_q;

endmodule

// File: sv/spcf_chk.sv
// port-level checker for the stepper position command block
`include "assert_macros.svh"

module spcf_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               tick_valid,
	input logic                               tick_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic [1:0]                         command,
	input logic signed [spcf_pkg::STEP_W-1:0] steps_to_move
);

	logic tick_acc;

	assign tick_acc = tick_valid && tick_ready;

	`SPCF_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped before taken")

	`SPCF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, tick_acc, !tick_ready, "new tick taken while one is in work")

	`SPCF_ASSERT_SAME(a_steps_only_on_move, clk, arst_n, result_valid && (command != spcf_pkg::CMD_MOVE), steps_to_move == '0, "nonzero steps without a move")

	`SPCF_ASSERT_NEXT(a_no_instant_result, clk, arst_n, tick_acc, !$rose(result_valid), "result offered right after a tick")

endmodule

bind stepper_position_command_fsm spcf_chk u_spcf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_valid    (tick.valid),
	.tick_ready    (tick.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.command       (result.command),
	.steps_to_move (result.steps_to_move)
);
